>>> sv/pidaws_pkg.sv
// ----------------------------------------------------------------------------
// pidaws_pkg
// Shared constants, command/status types and helpers of the PID controller.
// ----------------------------------------------------------------------------
package pidaws_pkg;

  // Build-time tuning of the controller.
  localparam int unsigned TOLERANCE_PERCENT = 0;
  localparam int unsigned INTEGRAL_WINDOW   = 0;
  localparam int unsigned DERIV_TAU_MS      = 0;

  localparam int unsigned SAT_W   = 62;  // saturated products, +-2^60
  localparam int unsigned DIV_W   = 61;  // dividend and quotient
  localparam int unsigned DVS_W   = 33;  // divisor
  localparam int unsigned FR_W    = 48;  // filtered rate
  localparam int unsigned ALPHA_W = 17;  // filter coefficient, Q16 up to 1.0

  localparam logic signed [SAT_W-1:0] SAT_LIM = 62'sh1000000000000000;
  localparam logic [DVS_W-1:0]        MS_PER_S = 33'd1000;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_FLOOR     = 3'd3,
    REG_CEILING   = 3'd4,
    REG_PERIOD    = 3'd5,
    REG_REVERSE   = 3'd6,
    REG_SLEW      = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_PREP,
    OP_DECIDE,
    OP_MULP,
    OP_DIVR,
    OP_DIVA,
    OP_MULF,
    OP_MULD,
    OP_MULE,
    OP_MULC,
    OP_DIVC,
    OP_MULI,
    OP_DIVI,
    OP_SUM,
    OP_MULS,
    OP_DIVS,
    OP_SLEW,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start_mul;
    logic start_div;
    logic exec;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic primed;
    logic due;
    logic el_zero;
    logic slew_on;
    logic out_busy;
  } sts_t;

  // Clamp to the output limits; ceiling first, so a crossed floor wins.
  function automatic logic signed [31:0] clamp_out(input logic signed [63:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [63:0] y;
    y = x;
    if (y > 64'(hi)) y = 64'(hi);
    if (y < 64'(lo)) y = 64'(lo);
    return y[31:0];
  endfunction

  function automatic logic signed [SAT_W-1:0] sat_add(input logic signed [SAT_W-1:0] a,
                                                      input logic signed [SAT_W-1:0] b);
    logic signed [SAT_W:0] s;
    s = (SAT_W+1)'(a) + (SAT_W+1)'(b);
    if (s > (SAT_W+1)'(SAT_LIM)) s = (SAT_W+1)'(SAT_LIM);
    else if (s < -(SAT_W+1)'(SAT_LIM)) s = -(SAT_W+1)'(SAT_LIM);
    return s[SAT_W-1:0];
  endfunction

endpackage

>>> sv/pidaws_mul.sv
// ----------------------------------------------------------------------------
// pidaws_mul
// Saturating magnitude multiplier, 61 x 32 bits in two 32 x 32 passes.
// ----------------------------------------------------------------------------
module pidaws_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [pidaws_pkg::SAT_W-1:0]    v_i,
  input  logic [31:0]                            g_i,
  input  logic                                   sh16_i,
  output logic                                   done_o,
  output logic signed [pidaws_pkg::SAT_W-1:0]    res_o
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HI   = 4'b0010,
    PH_LO   = 4'b0100,
    PH_SUM  = 4'b1000
  } ph_e;

  ph_e         ph_q, ph_d;
  logic [60:0] m_q;
  logic [31:0] g_q;
  logic        neg_q, sh_q, done_q;
  logic [60:0] hp_q;
  logic [63:0] lp_q;
  logic signed [pidaws_pkg::SAT_W-1:0] res_q, mag_v, res_d;
  logic [31:0] mul_a;
  logic [63:0] prod, lps;
  logic [60:0] sh_hp, sum61, r;
  logic        hp_big, lp_big;

  always_comb begin
    mag_v = v_i[pidaws_pkg::SAT_W-1] ? -v_i : v_i;
    mul_a = (ph_q == PH_HI) ? {3'b000, m_q[60:32]} : m_q[31:0];
    prod  = mul_a * g_q;
    hp_big = sh_q ? (|hp_q[60:44]) : (|hp_q[60:28]);
    lps    = sh_q ? {16'h0000, lp_q[63:16]} : lp_q;
    lp_big = |lps[63:60];
    sh_hp  = sh_q ? {1'b0, hp_q[43:0], 16'h0000} : {1'b0, hp_q[27:0], 32'h0};
    sum61  = sh_hp + {1'b0, lps[59:0]};
    if (hp_big || lp_big || (sum61 > 61'(pidaws_pkg::SAT_LIM))) begin
      r = 61'(pidaws_pkg::SAT_LIM);
    end else begin
      r = sum61;
    end
    res_d = neg_q ? -$signed({1'b0, r}) : $signed({1'b0, r});
    case (ph_q)
      PH_IDLE: ph_d = start_i ? PH_HI : PH_IDLE;
      PH_HI:   ph_d = PH_LO;
      PH_LO:   ph_d = PH_SUM;
      PH_SUM:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == PH_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && start_i) begin
      m_q   <= mag_v[60:0];
      g_q   <= g_i;
      neg_q <= v_i[pidaws_pkg::SAT_W-1];
      sh_q  <= sh16_i;
    end
    if (ph_q == PH_HI) hp_q <= prod[60:0];
    if (ph_q == PH_LO) lp_q <= prod;
    if (ph_q == PH_SUM) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/pidaws_div.sv
// ----------------------------------------------------------------------------
// pidaws_div
// Unsigned divider: restoring, one quotient bit per cycle, for a variable
// divisor; four 16-bit digits by reciprocal multiplication for division by
// the fixed 1000.
// ----------------------------------------------------------------------------
module pidaws_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            by1000_i,
  input  logic [pidaws_pkg::DIV_W-1:0]    dividend_i,
  input  logic [pidaws_pkg::DVS_W-1:0]    divisor_i,
  output logic                            done_o,
  output logic [pidaws_pkg::DIV_W-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(pidaws_pkg::DIV_W + 1);
  // ceil(2^36 / 1000): exact quotient for every 26-bit digit window
  localparam logic [26:0]      RECIP   = 27'd68719477;
  localparam logic [CNT_W-1:0] K_STEPS = CNT_W'(4);

  logic [CNT_W-1:0]                 cnt_q;
  logic                             busy_q, done_q;
  logic [pidaws_pkg::DVS_W:0]       rem_q, shifted, trial;
  logic [pidaws_pkg::DIV_W-1:0]     quo_q;
  logic [pidaws_pkg::DVS_W-1:0]     dvs_q;
  logic                             kmode_q;
  logic [63:0]                      kq_q;
  logic [9:0]                       krem_q;
  logic [25:0]                      ky, kback, kleft;
  logic [52:0]                      kprod;
  logic [15:0]                      kdig;

  always_comb begin
    shifted = {rem_q[pidaws_pkg::DVS_W-1:0], quo_q[pidaws_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    // one long-division digit step by 1000: remainder below 1000, 16 new bits
    ky      = {krem_q, kq_q[63:48]};
    kprod   = 53'(ky) * 53'(RECIP);
    kdig    = kprod[51:36];
    kback   = 26'(kdig) * 26'(pidaws_pkg::MS_PER_S);
    kleft   = ky - kback;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= by1000_i ? K_STEPS : CNT_W'(pidaws_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q   <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
      kmode_q <= by1000_i;
      kq_q    <= 64'(dividend_i);
      krem_q  <= '0;
    end else if (busy_q) begin
      if (kmode_q) begin
        kq_q   <= {kq_q[47:0], kdig};
        krem_q <= kleft[9:0];
      end else if (!trial[pidaws_pkg::DVS_W]) begin
        rem_q <= trial;
        quo_q <= {quo_q[pidaws_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[pidaws_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = kmode_q ? kq_q[pidaws_pkg::DIV_W-1:0] : quo_q;

endmodule

>>> sv/pidaws_dp.sv
// ----------------------------------------------------------------------------
// pidaws_dp
// Datapath: configuration, controller state, work registers, output word.
// ----------------------------------------------------------------------------
module pidaws_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [95:0]         s_tdata_i,
  input  logic                s_tuser_i,
  output logic [31:0]         m_tdata_o,
  output logic                m_tuser_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  pidaws_pkg::cmd_t    cmd_i,
  output pidaws_pkg::sts_t    sts_o
);

  localparam int unsigned SW = pidaws_pkg::SAT_W;
  localparam int unsigned FW = pidaws_pkg::FR_W;

  // configuration
  logic [31:0]        gain_p_q, gain_i_q, gain_d_q, slew_q;
  logic signed [31:0] floor_q, ceil_q;
  logic [15:0]        period_q;
  logic               rev_q;

  // controller state
  logic signed [SW-1:0] integ_q;
  logic signed [31:0]   prev_q, held_q;
  logic signed [FW-1:0] fr_q;
  logic [31:0]          last_q;
  logic                 primed_q;

  // input word and work registers
  logic signed [31:0]   tgt_q, meas_q;
  logic [31:0]          now_q, el_q;
  logic                 restart_q, allowed_q;
  logic signed [32:0]   err_q, diff_q;
  logic signed [FW-1:0] rawd_q;
  logic [pidaws_pkg::ALPHA_W-1:0] alpha_q;
  logic signed [SW-1:0] p_q, d_q, i_q, icand_q;
  logic signed [31:0]   outv_q;
  logic [pidaws_pkg::DIV_W-1:0] maxc_q;

  // output word
  logic [31:0] out_drive_q;
  logic        out_upd_q, out_valid_q;

  // combinational helpers
  logic signed [32:0]   raw_err, diff_d;
  logic [31:0]          elapsed, atgt;
  logic [32:0]          aerr, adiff;
  logic                 allow;
  logic signed [FW:0]   delta;
  logic signed [SW-1:0] mul_v, mres, q_s;
  logic [31:0]          mul_g;
  logic                 mul_sh, mul_done;
  logic [pidaws_pkg::DIV_W-1:0] dd, quot, mres_abs;
  logic [pidaws_pkg::DVS_W-1:0] dvs;
  logic                 div_k, div_done;
  logic [42:0]          adiff_ms;
  logic signed [FW-1:0] rate, rawd;
  logic signed [63:0]   cand, total, change, maxc_s, slewed;
  logic                 into_sat;

  always_comb begin
    raw_err = 33'(tgt_q) - 33'(meas_q);
    diff_d  = 33'(meas_q) - 33'(prev_q);
    elapsed = now_q - last_q;
    aerr    = raw_err[32] ? 33'(-raw_err) : 33'(raw_err);
    atgt    = tgt_q[31] ? 32'(-tgt_q) : 32'(tgt_q);
    allow   = (gain_i_q != '0)
           && ((40'(aerr) * 40'd100) > (40'(atgt) * 40'(pidaws_pkg::TOLERANCE_PERCENT)))
           && ((pidaws_pkg::INTEGRAL_WINDOW == 0)
               || (aerr <= 33'(pidaws_pkg::INTEGRAL_WINDOW)));
    delta   = (FW+1)'(rawd_q) - (FW+1)'(fr_q);
    adiff   = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
    adiff_ms = 43'(adiff) * 43'(pidaws_pkg::MS_PER_S);
    mres_abs = mres[SW-1] ? pidaws_pkg::DIV_W'(-mres) : pidaws_pkg::DIV_W'(mres);
    q_s     = mres[SW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    rate    = diff_q[32] ? -$signed(FW'(quot)) : $signed(FW'(quot));
    rawd    = rev_q ? rate : -rate;

    // operand select for the shared units
    mul_v  = '0;
    mul_g  = '0;
    mul_sh = 1'b0;
    case (cmd_i.op)
      pidaws_pkg::OP_MULP: begin mul_v = SW'(err_q);   mul_g = gain_p_q; mul_sh = 1'b1; end
      pidaws_pkg::OP_MULF: begin
        mul_v  = SW'(delta);
        mul_g  = 32'(alpha_q);
        mul_sh = 1'b1;
      end
      pidaws_pkg::OP_MULD: begin mul_v = SW'(fr_q);    mul_g = gain_d_q; mul_sh = 1'b1; end
      pidaws_pkg::OP_MULE: begin mul_v = SW'(err_q);   mul_g = el_q;     mul_sh = 1'b0; end
      pidaws_pkg::OP_MULC: begin mul_v = icand_q;      mul_g = gain_i_q; mul_sh = 1'b1; end
      pidaws_pkg::OP_MULI: begin mul_v = integ_q;      mul_g = gain_i_q; mul_sh = 1'b1; end
      pidaws_pkg::OP_MULS: begin mul_v = SW'(el_q);    mul_g = slew_q;   mul_sh = 1'b0; end
      default: ;
    endcase

    case (cmd_i.op)
      pidaws_pkg::OP_DIVR: begin
        dd    = pidaws_pkg::DIV_W'(adiff_ms);
        dvs   = pidaws_pkg::DVS_W'(el_q);
        div_k = 1'b0;
      end
      pidaws_pkg::OP_DIVA: begin
        dd    = pidaws_pkg::DIV_W'({el_q, 16'h0000});
        dvs   = pidaws_pkg::DVS_W'(pidaws_pkg::DERIV_TAU_MS) + pidaws_pkg::DVS_W'(el_q);
        div_k = 1'b0;
      end
      default: begin
        // product magnitude over 1000
        dd    = mres_abs;
        dvs   = pidaws_pkg::MS_PER_S;
        div_k = 1'b1;
      end
    endcase

    cand     = 64'(p_q) + 64'(q_s) + 64'(d_q);
    into_sat = ((cand > 64'(ceil_q)) && !err_q[32] && (err_q != '0))
            || ((cand < 64'(floor_q)) && err_q[32]);
    total    = 64'(p_q) + 64'(i_q) + 64'(d_q);
    change   = 64'(outv_q) - 64'(held_q);
    maxc_s   = 64'(maxc_q);
    if (change > maxc_s)       slewed = 64'(held_q) + maxc_s;
    else if (change < -maxc_s) slewed = 64'(held_q) - maxc_s;
    else                       slewed = 64'(outv_q);
  end

  pidaws_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_mul),
    .v_i     (mul_v),
    .g_i     (mul_g),
    .sh16_i  (mul_sh),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  pidaws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .by1000_i   (div_k),
    .dividend_i (dd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      floor_q     <= '0;
      ceil_q      <= 32'sd6553600;
      period_q    <= 16'd100;
      rev_q       <= 1'b0;
      slew_q      <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
      fr_q        <= '0;
      last_q      <= '0;
      primed_q    <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (pidaws_pkg::reg_idx_e'(cfg_index_i))
          pidaws_pkg::REG_GAIN_P:  gain_p_q <= cfg_data_i;
          pidaws_pkg::REG_GAIN_I:  gain_i_q <= cfg_data_i;
          pidaws_pkg::REG_GAIN_D:  gain_d_q <= cfg_data_i;
          pidaws_pkg::REG_FLOOR:   floor_q  <= cfg_data_i;
          pidaws_pkg::REG_CEILING: ceil_q   <= cfg_data_i;
          pidaws_pkg::REG_PERIOD:  if (cfg_data_i[15:0] != '0) period_q <= cfg_data_i[15:0];
          pidaws_pkg::REG_REVERSE: rev_q    <= cfg_data_i[0];
          pidaws_pkg::REG_SLEW:    slew_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.exec) begin
        case (cmd_i.op)
          pidaws_pkg::OP_PREP: begin
            if (restart_q) begin
              integ_q  <= '0;
              prev_q   <= '0;
              fr_q     <= '0;
              last_q   <= now_q;
              primed_q <= 1'b0;
              held_q   <= pidaws_pkg::clamp_out(64'(held_q), floor_q, ceil_q);
            end
          end
          pidaws_pkg::OP_DECIDE: begin
            if (!primed_q) begin
              prev_q   <= meas_q;
              fr_q     <= '0;
              last_q   <= now_q;
              primed_q <= 1'b1;
            end else if (elapsed >= 32'(period_q)) begin
              last_q <= now_q;
              if (elapsed != '0) prev_q <= meas_q;
            end
          end
          pidaws_pkg::OP_DIVR: if (pidaws_pkg::DERIV_TAU_MS == 0) fr_q <= rawd;
          pidaws_pkg::OP_MULF: fr_q <= fr_q + FW'(mres);
          pidaws_pkg::OP_DIVC: if (allowed_q && !into_sat) integ_q <= icand_q;
          pidaws_pkg::OP_SLEW: begin
            if (slew_q != '0) held_q <= pidaws_pkg::clamp_out(slewed, floor_q, ceil_q);
            else              held_q <= pidaws_pkg::clamp_out(64'(outv_q), floor_q, ceil_q);
          end
          default: ;
        endcase
      end

      if (cmd_i.exec && cmd_i.op == pidaws_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      case (cmd_i.op)
        pidaws_pkg::OP_LATCH: begin
          tgt_q     <= s_tdata_i[31:0];
          meas_q    <= s_tdata_i[63:32];
          now_q     <= s_tdata_i[95:64];
          restart_q <= s_tuser_i;
        end
        pidaws_pkg::OP_DECIDE: begin
          el_q      <= elapsed;
          err_q     <= rev_q ? -raw_err : raw_err;
          diff_q    <= diff_d;
          allowed_q <= allow;
        end
        pidaws_pkg::OP_MULP: p_q <= mres;
        pidaws_pkg::OP_DIVR: rawd_q <= rawd;
        pidaws_pkg::OP_DIVA: alpha_q <= quot[pidaws_pkg::ALPHA_W-1:0];
        pidaws_pkg::OP_MULD: d_q <= mres;
        pidaws_pkg::OP_MULE: icand_q <= allowed_q ? pidaws_pkg::sat_add(integ_q, mres) : integ_q;
        pidaws_pkg::OP_DIVI: i_q <= q_s;
        pidaws_pkg::OP_SUM:  outv_q <= pidaws_pkg::clamp_out(total, floor_q, ceil_q);
        pidaws_pkg::OP_DIVS: maxc_q <= quot;
        pidaws_pkg::OP_EMIT: begin
          out_drive_q <= held_q;
          out_upd_q   <= cmd_i.upd;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.mul_done = mul_done;
    sts_o.div_done = div_done;
    sts_o.primed   = primed_q;
    sts_o.due      = elapsed >= 32'(period_q);
    sts_o.el_zero  = (elapsed == '0);
    sts_o.slew_on  = (slew_q != '0);
    sts_o.out_busy = out_valid_q && !m_tready_i;
  end

  assign m_tdata_o  = out_drive_q;
  assign m_tuser_o  = out_upd_q;
  assign m_tvalid_o = out_valid_q;

endmodule

>>> sv/pidaws_ctrl.sv
// ----------------------------------------------------------------------------
// pidaws_ctrl
// Sequencer: walks one word through the multiplier and divider steps.
// ----------------------------------------------------------------------------
module pidaws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  pidaws_pkg::sts_t sts_i,
  output pidaws_pkg::cmd_t cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_PREP   = 18'h00002,
    ST_DECIDE = 18'h00004,
    ST_MULP   = 18'h00008,
    ST_DIVR   = 18'h00010,
    ST_DIVA   = 18'h00020,
    ST_MULF   = 18'h00040,
    ST_MULD   = 18'h00080,
    ST_MULE   = 18'h00100,
    ST_MULC   = 18'h00200,
    ST_DIVC   = 18'h00400,
    ST_MULI   = 18'h00800,
    ST_DIVI   = 18'h01000,
    ST_SUM    = 18'h02000,
    ST_MULS   = 18'h04000,
    ST_DIVS   = 18'h08000,
    ST_SLEW   = 18'h10000,
    ST_EMIT   = 18'h20000
  } state_e;

  state_e st_q, st_d, nxt;
  logic   go_q, go_d, upd_q, upd_d;
  logic   is_mul, is_div;

  always_comb begin
    st_d   = st_q;
    go_d   = go_q;
    upd_d  = upd_q;
    nxt    = st_q;
    is_mul = 1'b0;
    is_div = 1'b0;
    cmd_o  = '{op: pidaws_pkg::OP_NONE, start_mul: 1'b0, start_div: 1'b0,
               exec: 1'b0, upd: 1'b0};
    s_tready_o = 1'b0;

    case (st_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.op   = pidaws_pkg::OP_LATCH;
        cmd_o.exec = s_tvalid_i;
        if (s_tvalid_i) st_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.op   = pidaws_pkg::OP_PREP;
        cmd_o.exec = 1'b1;
        st_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.op   = pidaws_pkg::OP_DECIDE;
        cmd_o.exec = 1'b1;
        // compute only when primed, due and time has moved
        if (sts_i.primed && sts_i.due && !sts_i.el_zero) begin
          upd_d = 1'b1;
          st_d  = ST_MULP;
        end else begin
          upd_d = 1'b0;
          st_d  = ST_EMIT;
        end
      end
      ST_MULP: begin cmd_o.op = pidaws_pkg::OP_MULP; is_mul = 1'b1; nxt = ST_DIVR; end
      ST_DIVR: begin
        cmd_o.op = pidaws_pkg::OP_DIVR;
        is_div   = 1'b1;
        nxt      = (pidaws_pkg::DERIV_TAU_MS != 0) ? ST_DIVA : ST_MULD;
      end
      ST_DIVA: begin cmd_o.op = pidaws_pkg::OP_DIVA; is_div = 1'b1; nxt = ST_MULF; end
      ST_MULF: begin cmd_o.op = pidaws_pkg::OP_MULF; is_mul = 1'b1; nxt = ST_MULD; end
      ST_MULD: begin cmd_o.op = pidaws_pkg::OP_MULD; is_mul = 1'b1; nxt = ST_MULE; end
      ST_MULE: begin cmd_o.op = pidaws_pkg::OP_MULE; is_mul = 1'b1; nxt = ST_MULC; end
      ST_MULC: begin cmd_o.op = pidaws_pkg::OP_MULC; is_mul = 1'b1; nxt = ST_DIVC; end
      ST_DIVC: begin cmd_o.op = pidaws_pkg::OP_DIVC; is_div = 1'b1; nxt = ST_MULI; end
      ST_MULI: begin cmd_o.op = pidaws_pkg::OP_MULI; is_mul = 1'b1; nxt = ST_DIVI; end
      ST_DIVI: begin cmd_o.op = pidaws_pkg::OP_DIVI; is_div = 1'b1; nxt = ST_SUM; end
      ST_SUM: begin
        cmd_o.op   = pidaws_pkg::OP_SUM;
        cmd_o.exec = 1'b1;
        st_d       = sts_i.slew_on ? ST_MULS : ST_SLEW;
      end
      ST_MULS: begin cmd_o.op = pidaws_pkg::OP_MULS; is_mul = 1'b1; nxt = ST_DIVS; end
      ST_DIVS: begin cmd_o.op = pidaws_pkg::OP_DIVS; is_div = 1'b1; nxt = ST_SLEW; end
      ST_SLEW: begin
        cmd_o.op   = pidaws_pkg::OP_SLEW;
        cmd_o.exec = 1'b1;
        st_d       = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op  = pidaws_pkg::OP_EMIT;
        cmd_o.upd = upd_q;
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          st_d       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // launch the unit once, then wait for its done pulse
    if (is_mul || is_div) begin
      if (!go_q) begin
        cmd_o.start_mul = is_mul;
        cmd_o.start_div = is_div;
        go_d            = 1'b1;
      end else if ((is_mul && sts_i.mul_done) || (is_div && sts_i.div_done)) begin
        cmd_o.exec = 1'b1;
        go_d       = 1'b0;
        st_d       = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      go_q  <= 1'b0;
      upd_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      go_q  <= go_d;
      upd_q <= upd_d;
    end
  end

endmodule

>>> sv/pid_antiwindup_slew_controller_core.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_slew_controller_core
// PID controller, Q16.16, with conditional integration, filtered derivative
// and slew-limited, clamped output.
// ----------------------------------------------------------------------------
// Held output: a word that only holds the output (first sample, restart or period
//   not yet elapsed) passes PREP, DECIDE and EMIT before its output word goes valid.
// A computed word takes one pass of the bit-serial divider for the rate, five
//   multiplier passes and two divide-by-1000 passes; the slew limit adds a
//   multiplier and a divide-by-1000 pass, and a derivative filter adds a bit-serial
//   divide and a multiplier pass. One word is in work at a time; the next is taken
//   from the cycle in which the output word goes valid, and an output stall holds.
// Reset (rst_ni low, async): registers take their documented defaults, the
//   integrator, filter and held output clear, and the first word only primes.
// ----------------------------------------------------------------------------
module pid_antiwindup_slew_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // target[31:0], measured[63:32], now_ms[95:64]
  input  logic        s_axis_tuser,   // restart
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // drive[31:0]
  output logic        m_axis_tuser    // updated
);

  pidaws_pkg::cmd_t cmd;
  pidaws_pkg::sts_t sts;

  // Always ready; users must land writes while idle; the block does not check it.
  assign cfg_ready_o = 1'b1;

  // Sequencer: accepts a word only when idle, then steps through the
  // shared multiplier and divider and hands the result to the output stage.
  pidaws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: holds configuration, integrator and filter state, and the
  // output register that parts the two stream sides.
  pidaws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> sv/pidaws_checker.sv
// ----------------------------------------------------------------------------
// pidaws_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidaws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
    else $error("second word taken or result too early");

  a_free_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not reopened with a new result");

endmodule

bind pid_antiwindup_slew_controller_core pidaws_checker u_pidaws_checker (.*);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// PID controller core testbench
// Streams setpoint/measurement/timestamp words into the core under random
// source gaps and sink stalls, predicts every output word with a cycle-free
// fixed-point model of the controller, and checks drive and updated flags.
// Runs one directed phase, then several register settings including extremes.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 400;   // longer than a computed word takes
  localparam int unsigned LONG_HOLD = 1000;
  localparam logic [63:0] PROD_LIM = 64'h1000_0000_0000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct {
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic [31:0]        now_ms;
    logic               restart;
  } sample_t;

  typedef struct {
    logic [31:0] drive;
    logic        updated;
  } drive_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  pid_antiwindup_slew_controller_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  // Register shadows, as the core should hold them.
  logic [31:0]        gain_p, gain_i, gain_d, slew_rate;
  logic signed [31:0] out_floor, out_ceiling;
  logic [15:0]        period_ms;
  logic               reverse;

  // Controller state shadows.
  logic signed [63:0] integ_sum, prev_meas, filt_rate, held_drive;
  logic [31:0]        last_ms;
  logic               primed;

  sample_t     sample_q[$];
  drive_word_t drive_expect_q[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0, words_checked = 0, words_computed = 0;
  int unsigned src_gap = 0, rx_stall = 0, rx_hold_left = 0;
  int unsigned long_req = 0, long_seen = 0;
  logic        src_pause = 1'b0;
  logic        steady = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // (v * g) >> sh on the magnitude, saturated to +-2^60
  function automatic logic signed [63:0] sat_mul(input logic signed [63:0] v,
                                                 input logic [31:0] g, input int sh);
    logic [63:0] m, hi, lo, hp, lp, r;
    m = mag(v);
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    hp = hi * {32'd0, g};
    if (hp >= (64'd1 << (28 + sh))) begin
      r = PROD_LIM;
    end else begin
      lp = (lo * {32'd0, g}) >> sh;
      if (lp >= PROD_LIM) begin
        r = PROD_LIM;
      end else begin
        r = (hp << (32 - sh)) + lp;
        if (r > PROD_LIM) r = PROD_LIM;
      end
    end
    return v < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > $signed(PROD_LIM)) s = $signed(PROD_LIM);
    if (s < -$signed(PROD_LIM)) s = -$signed(PROD_LIM);
    return s;
  endfunction

  // Ceiling first, so a crossed floor wins.
  function automatic logic signed [63:0] limit_drive(input logic signed [63:0] x);
    logic signed [63:0] lo, hi, y;
    lo = out_floor;
    hi = out_ceiling;
    y = x;
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Controller prediction: advance the state by one sample, queue its word
  // --------------------------------------------------------------------------
  task automatic advance_controller(input sample_t s);
    logic signed [63:0] tgt, meas, raw_err, err, p, d, icand, cand, outv;
    logic signed [63:0] diff, rate, raw_d, delta, maxc, change;
    logic [63:0] aerr, rm, alpha, fstep;
    logic [31:0] elapsed;
    logic allowed, into_sat, upd;
    drive_word_t w;
    tgt = s.target;
    meas = s.measured;
    upd = 1'b0;
    if (s.restart) begin
      integ_sum = 0;
      prev_meas = 0;
      filt_rate = 0;
      last_ms = s.now_ms;
      primed = 1'b0;
      held_drive = limit_drive(held_drive);
    end
    elapsed = s.now_ms - last_ms;
    if (!primed) begin
      prev_meas = meas;
      filt_rate = 0;
      last_ms = s.now_ms;
      primed = 1'b1;
    end else if (elapsed >= {16'd0, period_ms}) begin
      last_ms = s.now_ms;
      if (elapsed != 0) begin
        raw_err = tgt - meas;
        err = reverse ? -raw_err : raw_err;
        aerr = mag(raw_err);
        p = sat_mul(err, gain_p, 16);

        diff = meas - prev_meas;
        rm = (mag(diff) * 64'd1000) / {32'd0, elapsed};
        rate = diff < 0 ? -$signed(rm) : $signed(rm);
        raw_d = reverse ? rate : -rate;
        if (pidaws_pkg::DERIV_TAU_MS > 0) begin
          alpha = ({32'd0, elapsed} << 16) /
                  (64'(pidaws_pkg::DERIV_TAU_MS) + {32'd0, elapsed});
          delta = raw_d - filt_rate;
          fstep = (mag(delta) * alpha) >> 16;
          filt_rate = filt_rate + (delta < 0 ? -$signed(fstep) : $signed(fstep));
        end else begin
          filt_rate = raw_d;
        end
        d = sat_mul(filt_rate, gain_d, 16);
        prev_meas = meas;

        // conditional integration: enabled, outside tolerance, inside window
        allowed = gain_i != 0 &&
                  aerr * 100 > mag(tgt) * 64'(pidaws_pkg::TOLERANCE_PERCENT);
        if (pidaws_pkg::INTEGRAL_WINDOW > 0 && aerr > 64'(pidaws_pkg::INTEGRAL_WINDOW))
          allowed = 1'b0;

        icand = integ_sum;
        if (allowed) icand = sum_sat(icand, sat_mul(err, elapsed, 0));
        cand = p + sat_mul(icand, gain_i, 16) / 64'sd1000 + d;
        into_sat = (cand > 64'(out_ceiling) && err > 0) ||
                   (cand < 64'(out_floor) && err < 0);
        if (allowed && !into_sat) integ_sum = icand;

        outv = limit_drive(p + sat_mul(integ_sum, gain_i, 16) / 64'sd1000 + d);
        if (slew_rate != 0) begin
          maxc = sat_mul({32'd0, elapsed}, slew_rate, 0) / 64'sd1000;
          change = outv - held_drive;
          if (change > maxc) outv = held_drive + maxc;
          else if (change < -maxc) outv = held_drive - maxc;
        end
        held_drive = limit_drive(outv);
        upd = 1'b1;
      end
    end
    w.drive = held_drive[31:0];
    w.updated = upd;
    drive_expect_q.push_back(w);
  endtask

  // --------------------------------------------------------------------------
  // Register writes, only while the core is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(input pidaws_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pidaws_pkg::REG_GAIN_P:  gain_p = value;
      pidaws_pkg::REG_GAIN_I:  gain_i = value;
      pidaws_pkg::REG_GAIN_D:  gain_d = value;
      pidaws_pkg::REG_FLOOR:   out_floor = value;
      pidaws_pkg::REG_CEILING: out_ceiling = value;
      pidaws_pkg::REG_PERIOD:  if (value[15:0] != 0) period_ms = value[15:0];
      pidaws_pkg::REG_REVERSE: reverse = value[0];
      pidaws_pkg::REG_SLEW:    slew_rate = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] gp, gi, gd, lo, hi, per, rev, slew);
    write_reg(pidaws_pkg::REG_GAIN_P, gp);
    write_reg(pidaws_pkg::REG_GAIN_I, gi);
    write_reg(pidaws_pkg::REG_GAIN_D, gd);
    write_reg(pidaws_pkg::REG_FLOOR, lo);
    write_reg(pidaws_pkg::REG_CEILING, hi);
    write_reg(pidaws_pkg::REG_PERIOD, per);
    write_reg(pidaws_pkg::REG_REVERSE, rev);
    write_reg(pidaws_pkg::REG_SLEW, slew);
  endtask

  // Hold until every queued sample is accepted and every word has come back,
  // then let a computation in flight finish.
  task automatic wait_idle();
    while (sample_q.size() != 0 || s_tvalid || drive_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [31:0] t, m, now, input logic rs);
    sample_t s;
    s.target = t;
    s.measured = m;
    s.now_ms = now;
    s.restart = rs;
    sample_q.push_back(s);
  endtask

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  function automatic int unsigned rnd_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rnd_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 26214400) - 13107200;   // +-200.0
    if (r < 65) return $urandom();
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  // Queue n samples with a plausible clock: mostly due, some early, some jumps.
  task automatic push_random(input int n, inout logic [31:0] now);
    logic [31:0] t, m;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) now += period_ms + $urandom_range(0, period_ms);
      else if (r < 80) now += $urandom_range(0, period_ms - 1);
      else if (r < 90) now += $urandom();
      else now += period_ms;
      t = rnd_value();
      r = $urandom_range(0, 99);
      if (r < 30) m = t;
      else if (r < 60) m = t + $urandom_range(0, 655360) - 327680;
      else m = rnd_value();
      push_sample(t, m, now, $urandom_range(0, 99) < 4);
    end
  endtask

  // --------------------------------------------------------------------------
  // Source driver: present one queued sample per word, random gaps between
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        // word taken at this edge: the prediction follows acceptance order
        s.target = s_tdata[31:0];
        s.measured = s_tdata[63:32];
        s.now_ms = s_tdata[95:64];
        s.restart = s_tuser;
        advance_controller(s);
        words_sent++;
      end
      if (src_gap != 0 && !steady) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() != 0 && !src_pause) begin
        s = sample_q.pop_front();
        s_tdata <= {s.now_ms, s.measured, s.target};
        s_tuser <= s.restart;
        s_tvalid <= 1'b1;
        src_gap <= rnd_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here, requested by the sequence
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_left <= 0;
      long_seen <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (long_seen != long_req) begin
      long_seen <= long_req;
      rx_hold_left <= LONG_HOLD;
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random back-pressure and checking of every output word
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    drive_word_t w;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (m_tuser) words_computed++;
        if (drive_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected word drive=%h updated=%b", m_tdata, m_tuser);
        end else begin
          w = drive_expect_q.pop_front();
          if (m_tdata !== w.drive || m_tuser !== w.updated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: word %0d drive exp %h got %h, updated exp %b got %b",
                       words_checked, w.drive, m_tdata, w.updated, m_tuser);
          end
        end
      end
      if (rx_hold_left != 0 || long_seen != long_req) begin
        m_tready <= 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        rx_stall <= rnd_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ERROR: timeout, %0d words still expected", drive_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] now;
    gain_p = 0; gain_i = 0; gain_d = 0; slew_rate = 0;
    out_floor = 0; out_ceiling = 32'd6553600; period_ms = 16'd100; reverse = 1'b0;
    integ_sum = 0; prev_meas = 0; filt_rate = 0; held_drive = 0;
    last_ms = 0; primed = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: priming, held output, extreme errors, restart, clock wrap
    write_all(Q_ONE, 32'h0000_8000, 32'h0000_0100, -32'sd6553600, 32'd6553600,
              32'd10, 32'd0, 32'd0);
    push_sample(0, 0, 32'd1000, 1'b0);
    push_sample(32'd6553600, 32'd3276800, 32'd1010, 1'b0);
    push_sample(32'd6553600, 32'd3276800, 32'd1015, 1'b0);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd1030, 1'b0);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd1040, 1'b0);
    push_sample(0, 0, 32'd1050, 1'b0);
    push_sample(32'd655360, 0, 32'd1052, 1'b1);
    push_sample(32'd655360, 0, 32'd1062, 1'b0);
    push_sample(32'd655360, 32'd327680, 32'hFFFF_FFF8, 1'b0);
    push_sample(32'd655360, 32'd327680, 32'h0000_0004, 1'b0);
    push_sample(-32'sd3276800, -32'sd3276800, 32'h20, 1'b0);
    push_sample(Q_ONE, -Q_ONE, 32'h30, 1'b0);
    push_sample(32'hFFFF_FFFF, 0, 32'h40, 1'b0);
    wait_idle();

    // Moderate gains, direct action, no slew limit
    now = 32'h40;
    write_all(32'h0002_0000, 32'h0000_8000, 32'h0000_0800, -32'sd6553600, 32'd6553600,
              32'd20, 32'd0, 32'd0);
    push_random(75, now);
    wait_idle();

    // Full-scale gains and limits, reverse action; long sink hold-off mid-run
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'd1, 32'd1, 32'd3276800);
    push_random(75, now);
    while (sample_q.size() > 65) @(posedge clk_i);
    long_req++;
    wait_idle();

    // Crossed limits, longest period, tiny slew; a zero period write is dropped
    write_all($urandom(), $urandom_range(0, 65535), $urandom(), 32'd655360,
              -32'sd655360, 32'd65535, 32'd0, 32'd1);
    write_reg(pidaws_pkg::REG_PERIOD, 32'd0);
    push_random(70, now);
    while (sample_q.size() > 35) @(posedge clk_i);
    src_pause <= 1'b1;
    while (s_tvalid || drive_expect_q.size() != 0) @(posedge clk_i);
    src_pause <= 1'b0;
    wait_idle();

    // Zero gains and limits, widest slew, clock near wrap, no idling
    steady = 1'b1;
    now = 32'hFFFF_0000;
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd100, 32'd1, 32'hFFFF_FFFF);
    push_random(70, now);
    wait_idle();
    steady = 1'b0;

    // Random settings with an ordered output range
    repeat (2) begin
      write_all($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
                $urandom_range(0, 32'h0000_4000), -$urandom_range(0, 32'h0400_0000),
                $urandom_range(1, 32'h0400_0000), $urandom_range(1, 50),
                $urandom_range(0, 1),
                $urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 32'h0100_0000));
      push_random(70, now);
      wait_idle();
    end

    $display("Covered %0d input words, %0d output words checked (%0d computed),",
             words_sent, words_checked, words_computed);
    $display("over the directed run and six further register settings, %0d mismatches.",
             mismatches);
    if (mismatches == 0 && drive_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
